// ===== src/fpsct_pkg.sv =====
// Package for the fixed-point sine/cosine/tangent block: types, constants and helpers.
// No dependencies.
`timescale 1ns / 1ps
package fpsct_pkg;

	localparam int unsigned FracBitsDef = 32;
	localparam int unsigned MaxTermsDef = 7;
	localparam logic [63:0] PiQ62 = 64'hC90FDAA22168C235;

	typedef enum logic [1:0] {
		MODE_SIN = 2'd0,
		MODE_COS = 2'd1,
		MODE_TAN = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	// Shared unit operations
	typedef enum logic [2:0] {
		OP_MUL = 3'd0,
		OP_DIVK = 3'd1,
		OP_MOD = 3'd2,
		OP_DIV = 3'd3,
		OP_NOP = 3'd4
	} op_t;

	typedef struct packed {
		logic start;
		op_t op;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] res;
	} unit_rsp_t;

	function automatic logic [7:0] series_div(input logic [2:0] i);
		logic [7:0] r;
		begin
			unique case (i)
				3'd0: r = 8'd6;
				3'd1: r = 8'd20;
				3'd2: r = 8'd42;
				3'd3: r = 8'd72;
				3'd4: r = 8'd110;
				3'd5: r = 8'd156;
				3'd6: r = 8'd210;
				default: r = 8'd1;
			endcase
			return r;
		end
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

endpackage

// ===== src/fpsct_unit.sv =====
// Shared arithmetic unit: 32x32 partial-product multiplier, reciprocal division by constants
// and a bit-serial restoring divider. Depends on fpsct_pkg.
`timescale 1ns / 1ps
module fpsct_unit import fpsct_pkg::*; #(
	parameter int unsigned FRAC_BITS = FracBitsDef
) (
	input logic clk,
	input logic arst_n,
	input unit_req_t req,
	output unit_rsp_t rsp
);
	localparam logic [63:0] Two = 64'((PiQ62 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS));
	localparam int unsigned TwoSh = $clog2(Two + 64'd1) - 1;
	localparam logic [63:0] TwoRcp = 64'((128'd1 << (64 + TwoSh)) / 128'(Two));

	typedef enum logic [5:0] {
		U_IDLE = 6'b000001,
		U_MUL = 6'b000010,
		U_RCP = 6'b000100,
		U_FIX = 6'b001000,
		U_DIV = 6'b010000,
		U_FIN = 6'b100000
	} ustate_t;

	// Reciprocal floor(2^(64+sh)/k) and sh for each series divisor
	function automatic logic [69:0] kdiv_rcp(input logic [7:0] k);
		logic [69:0] r;
		begin
			unique case (k)
				8'd6: r = {6'd2, 64'((128'd1 << 66) / 128'd6)};
				8'd20: r = {6'd4, 64'((128'd1 << 68) / 128'd20)};
				8'd42: r = {6'd5, 64'((128'd1 << 69) / 128'd42)};
				8'd72: r = {6'd6, 64'((128'd1 << 70) / 128'd72)};
				8'd110: r = {6'd6, 64'((128'd1 << 70) / 128'd110)};
				8'd156: r = {6'd7, 64'((128'd1 << 71) / 128'd156)};
				8'd210: r = {6'd7, 64'((128'd1 << 71) / 128'd210)};
				default: r = {6'd0, 64'd1};
			endcase
			return r;
		end
	endfunction

	ustate_t state_q;
	op_t op_q;
	logic neg_q;
	logic sgn_a_q;
	logic ph_q;
	logic [63:0] ua_q;
	logic [63:0] ub_q;
	logic [127:0] acc_q;
	logic [1:0] pp_q;
	logic [127:0] num_q;
	logic [63:0] rem_q;
	logic [127:0] quo_q;
	logic [6:0] cnt_q;
	logic [63:0] x_q;
	logic [63:0] d_q;
	logic [63:0] q_q;
	logic [5:0] sh_q;
	logic [63:0] res_q;
	logic done_q;

	logic [31:0] pa;
	logic [31:0] pb;
	logic [63:0] pprod;
	logic [127:0] pshift;
	logic [64:0] rem_sh;
	logic [64:0] rem_sub;
	logic [127:0] mul_sgn;
	logic [127:0] mul_sh;
	logic [63:0] mul_res;
	logic [63:0] div_res;
	logic [63:0] ql;
	logic [63:0] lim;
	logic [69:0] krcp;
	logic [63:0] qest;
	logic fix;
	logic [63:0] cq;
	logic [63:0] crem;

	always_comb begin
		pa = pp_q[1] ? ua_q[63:32] : ua_q[31:0];
		pb = pp_q[0] ? ub_q[63:32] : ub_q[31:0];
		pprod = 64'(pa) * 64'(pb);
		pshift = 128'(pprod) << (7'(pp_q[1]) * 7'd32 + 7'(pp_q[0]) * 7'd32);
	end

	always_comb begin
		rem_sh = {rem_q, num_q[127]};
		rem_sub = rem_sh - {1'b0, ub_q};
	end

	always_comb begin
		krcp = kdiv_rcp(req.b[7:0]);
		// Estimate is the true quotient or one below it
		qest = acc_q[127:64] >> sh_q;
	end

	// Multiply result: shift, saturate
	always_comb begin
		mul_sgn = neg_q ? (128'd0 - acc_q) : acc_q;
		mul_sh = mul_sgn >> FRAC_BITS;
		if (mul_sgn[127:63 + FRAC_BITS] != '0 && mul_sgn[127:63 + FRAC_BITS] != '1)
			mul_res = neg_q ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
		else
			mul_res = mul_sh[63:0];
	end

	always_comb begin
		ql = quo_q[63:0];
		lim = neg_q ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
		fix = (rem_q >= d_q);
		cq = q_q + {63'd0, fix};
		crem = fix ? (rem_q - d_q) : rem_q;
		unique case (op_q)
			OP_DIVK: div_res = neg_q ? (64'd0 - cq) : cq;
			OP_MOD: div_res = crem;
			OP_DIV: begin
				div_res = neg_q ? (64'd0 - ql) : ql;
				if (ub_q == '0)
					div_res = sgn_a_q ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
				else if (quo_q[127:64] != '0 || ql > lim)
					div_res = lim;
			end
			default: div_res = ql;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						sgn_a_q <= req.a[63];
						ua_q <= mag64(req.a);
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= '0;
						acc_q <= '0;
						pp_q <= '0;
						ph_q <= 1'b0;
						unique case (req.op)
							OP_MUL: begin
								ub_q <= mag64(req.b);
								neg_q <= req.a[63] ^ req.b[63];
								state_q <= U_MUL;
							end
							OP_DIVK: begin
								ub_q <= krcp[63:0];
								sh_q <= krcp[69:64];
								d_q <= req.b;
								x_q <= mag64(req.a);
								neg_q <= req.a[63];
								state_q <= U_MUL;
							end
							OP_MOD: begin
								ub_q <= TwoRcp;
								sh_q <= 6'(TwoSh);
								d_q <= req.b;
								x_q <= mag64(req.a);
								neg_q <= 1'b0;
								state_q <= U_MUL;
							end
							OP_DIV: begin
								ub_q <= mag64(req.b);
								neg_q <= req.a[63] ^ req.b[63];
								num_q <= {mag64(req.a), 64'd0} >> (64 - FRAC_BITS);
								state_q <= (req.b == '0) ? U_FIN : U_DIV;
							end
							default: begin
								res_q <= req.a;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				U_MUL: begin
					acc_q <= acc_q + pshift;
					pp_q <= pp_q + 2'd1;
					if (pp_q == 2'd3) begin
						if (op_q == OP_MUL)
							state_q <= U_FIN;
						else if (ph_q)
							state_q <= U_FIX;
						else
							state_q <= U_RCP;
					end
				end
				U_RCP: begin
					// Multiply the estimate back by the divisor
					q_q <= qest;
					ua_q <= qest;
					ub_q <= d_q;
					acc_q <= '0;
					pp_q <= '0;
					ph_q <= 1'b1;
					state_q <= U_MUL;
				end
				U_FIX: begin
					rem_q <= x_q - acc_q[63:0];
					state_q <= U_FIN;
				end
				U_DIV: begin
					// One quotient bit per cycle
					num_q <= num_q << 1;
					if (rem_sh[64] || !rem_sub[64]) begin
						rem_q <= rem_sub[63:0];
						quo_q <= {quo_q[126:0], 1'b1};
					end else begin
						rem_q <= rem_sh[63:0];
						quo_q <= {quo_q[126:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127)
						state_q <= U_FIN;
				end
				U_FIN: begin
					res_q <= (op_q == OP_MUL) ? mul_res : div_res;
					done_q <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;
endmodule

// ===== src/fpsct_seq.sv =====
// Sequencer: reduction, quadrant fold, Taylor series and tangent division over the shared unit.
// Depends on fpsct_pkg.
`timescale 1ns / 1ps
module fpsct_seq import fpsct_pkg::*; #(
	parameter int unsigned FRAC_BITS = FracBitsDef,
	parameter int unsigned MAX_TERMS = MaxTermsDef
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] mode,
	input logic [63:0] angle,
	input logic hold,
	output logic busy,
	output logic done,
	output logic [63:0] result,
	output logic tan_guarded,
	output unit_req_t req,
	input unit_rsp_t rsp
);
	localparam logic [63:0] Pi = 64'((PiQ62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
	localparam logic [63:0] Half = 64'((PiQ62 + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS));
	localparam logic [63:0] Two = 64'((PiQ62 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS));
	localparam logic [63:0] Thr = 64'd1 << (FRAC_BITS - 24);
	localparam logic [63:0] Guard = 64'd1 << (FRAC_BITS - 20);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_RED = 11'b00000000010,
		S_FOLD = 11'b00000000100,
		S_X2 = 11'b00000001000,
		S_CHK = 11'b00000010000,
		S_TMUL = 11'b00000100000,
		S_TDIV = 11'b00001000000,
		S_SDONE = 11'b00010000000,
		S_TQ = 11'b00100000000,
		S_OUT = 11'b01000000000,
		S_WAIT = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t ret_q;
	logic [1:0] mode_q;
	logic [63:0] angle_q;
	logic [63:0] red_q;
	logic [63:0] x_q;
	logic [63:0] x2_q;
	logic [63:0] term_q;
	logic [63:0] sum_q;
	logic [2:0] idx_q;
	logic neg_q;
	logic pass_q;
	logic [63:0] sin_q;
	logic [63:0] res_q;
	logic guard_q;
	logic done_q;

	logic [63:0] r_mod;
	logic [63:0] n_val;
	logic [63:0] n_cos;

	always_comb begin
		// Signed remainder from unsigned modulo of the magnitude
		r_mod = angle_q[63] ? (64'd0 - rsp.res) : rsp.res;
		if ($signed(r_mod) < 0)
			r_mod = r_mod + Two;
		n_cos = red_q + Half;
		if (n_cos >= Two)
			n_cos = n_cos - Two;
		n_val = pass_q ? n_cos : red_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			req.start <= 1'b0;
		end else begin
			done_q <= 1'b0;
			req.start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						angle_q <= angle;
						req <= '{start: 1'b1, op: OP_MOD, a: mag64(angle), b: Two};
						state_q <= S_WAIT;
						ret_q <= S_RED;
					end
				end
				S_WAIT: begin
					if (rsp.done)
						state_q <= ret_q;
				end
				S_RED: begin
					red_q <= r_mod;
					pass_q <= (mode_q == MODE_COS);
					if (mode_q == MODE_NONE) begin
						res_q <= '0;
						guard_q <= 1'b0;
						state_q <= S_OUT;
					end else
						state_q <= S_FOLD;
				end
				S_FOLD: begin
					// Quadrant fold of n
					if (n_val <= Half) begin
						x_q <= n_val; neg_q <= 1'b0;
					end else if (n_val <= Pi) begin
						x_q <= Pi - n_val; neg_q <= 1'b0;
					end else if (n_val <= Pi + Half) begin
						x_q <= n_val - Pi; neg_q <= 1'b1;
					end else begin
						x_q <= Two - n_val; neg_q <= 1'b1;
					end
					state_q <= S_X2;
				end
				S_X2: begin
					req <= '{start: 1'b1, op: OP_MUL, a: x_q, b: x_q};
					term_q <= x_q;
					sum_q <= x_q;
					idx_q <= '0;
					state_q <= S_WAIT;
					ret_q <= S_CHK;
				end
				S_CHK: begin
					if (idx_q == 3'd0)
						x2_q <= rsp.res;
					if (32'(idx_q) < MAX_TERMS && mag64(term_q) > Thr) begin
						req <= '{start: 1'b1, op: OP_MUL, a: term_q,
							b: (idx_q == 3'd0) ? rsp.res : x2_q};
						state_q <= S_WAIT;
						ret_q <= S_TMUL;
					end else
						state_q <= S_SDONE;
				end
				S_TMUL: begin
					req <= '{start: 1'b1, op: OP_DIVK, a: rsp.res,
						b: 64'(series_div(idx_q))};
					state_q <= S_WAIT;
					ret_q <= S_TDIV;
				end
				S_TDIV: begin
					term_q <= rsp.res;
					sum_q <= idx_q[0] ? (sum_q + rsp.res) : (sum_q - rsp.res);
					idx_q <= idx_q + 3'd1;
					state_q <= S_CHK;
				end
				S_SDONE: begin
					if (mode_q == MODE_TAN && !pass_q) begin
						// Sine done; run the cosine pass
						sin_q <= neg_q ? (64'd0 - sum_q) : sum_q;
						pass_q <= 1'b1;
						state_q <= S_FOLD;
					end else if (mode_q == MODE_TAN) begin
						res_q <= '0;
						guard_q <= 1'b0;
						if (mag64(neg_q ? (64'd0 - sum_q) : sum_q) < Guard) begin
							guard_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							req <= '{start: 1'b1, op: OP_DIV, a: sin_q,
								b: neg_q ? (64'd0 - sum_q) : sum_q};
							state_q <= S_WAIT;
							ret_q <= S_TQ;
						end
					end else begin
						res_q <= neg_q ? (64'd0 - sum_q) : sum_q;
						guard_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_TQ: begin
					res_q <= rsp.res;
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Hold the result until the output register is free
					if (!hold) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;
	assign tan_guarded = guard_q;
endmodule

// ===== src/fixed_point_sin_cos_tan.sv =====
// Top level of the fixed-point sine/cosine/tangent block: stream ports and output register.
// Depends on fpsct_pkg, fpsct_seq, fpsct_unit.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_axis_*: tuser = mode (0 sine, 1 cosine, 2 tangent, 3 gives 0),
//   tdata = signed angle, FRAC_BITS fraction bits.
//   Master channel m_axis_*: tdata = signed result, tuser = tan_guarded.
//   One request yields exactly one result.
//   One shared unit serves every step. A division by a constant is a reciprocal
//   multiply, a back multiply and a correction; the tangent division takes one
//   quotient bit per cycle over 128 bits. Tangent runs the sine and cosine series,
//   then the division unless guarded; mode 3 runs only the angle reduction.
//   s_axis_tready is high only while the sequencer is idle; one request at a time, so
//   the next request can be taken as the result is passed to the output register.
//   The result waits in an output register; a stalled receiver holds it while the next
//   request runs, and the sequencer holds its own result until the register is free.
//   Reset clears the sequencer, the unit and the output valid.
module fixed_point_sin_cos_tan import fpsct_pkg::*; #(
	parameter int unsigned FRAC_BITS = FracBitsDef,
	parameter int unsigned MAX_TERMS = MaxTermsDef
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata,  // [63:0] angle
	input logic [1:0] s_axis_tuser,   // [1:0] mode
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // [63:0] result
	output logic m_axis_tuser         // [0] tan_guarded
);
	unit_req_t req;
	unit_rsp_t rsp;
	logic busy;
	logic done;
	logic [63:0] res;
	logic guard;
	logic ovalid_q;
	logic [63:0] odata_q;
	logic ouser_q;

	assign s_axis_tready = !busy;

	fpsct_seq #(.FRAC_BITS(FRAC_BITS), .MAX_TERMS(MAX_TERMS)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.start(s_axis_tvalid && s_axis_tready),
		.mode(s_axis_tuser), .angle(s_axis_tdata),
		.hold(ovalid_q && !m_axis_tready),
		.busy(busy), .done(done), .result(res), .tan_guarded(guard),
		.req(req), .rsp(rsp)
	);

	fpsct_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (done) begin
				ovalid_q <= 1'b1;
				odata_q <= res;
				ouser_q <= guard;
			end else if (m_axis_tready)
				ovalid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign m_axis_tuser = ouser_q;
endmodule

// ===== src/fpsct_chk.sv =====
// Port checker for fixed_point_sin_cos_tan, bound to the top level.
// Depends on fixed_point_sin_cos_tan.
`timescale 1ns / 1ps
module fpsct_chk (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic m_axis_tuser
);
	// Stalled guard flag holds
	a_user_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tuser))
		else $error("guard flag changed while stalled");
	// Accepted request drops ready next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after request");
	// Guarded result is zero
	a_guard: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0)) else $error("guard nonzero");
	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped");
endmodule

bind fixed_point_sin_cos_tan fpsct_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// ===== dv/tb_fixed_point_sin_cos_tan.sv =====
// Testbench for fixed_point_sin_cos_tan: directed table, then random requests in all four modes,
// each result checked against a fixed-point series predictor. Depends on fpsct_pkg.
`timescale 1ns / 1ps
module tb_fixed_point_sin_cos_tan;
	import fpsct_pkg::*;

	localparam int FB = FracBitsDef;
	localparam int NTERMS = MaxTermsDef;
	localparam longint PI_FX = longint'((PiQ62 + (64'd1 << (61 - FB))) >> (62 - FB));
	localparam longint HALF_PI_FX = longint'((PiQ62 + (64'd1 << (62 - FB))) >> (63 - FB));
	localparam longint TWO_PI_FX = longint'((PiQ62 + (64'd1 << (60 - FB))) >> (61 - FB));
	localparam longint ONE_FX = longint'(64'd1 << FB);
	localparam longint MAX_CYCLES = 12000000;
	localparam int N_RANDOM = 1000;

	typedef struct {
		mode_t mode;
		longint angle;
		bit known;
		longint res;
		bit guard;
	} vec_t;

	typedef struct {
		longint res;
		bit guard;
	} trig_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;

	trig_t pending_q[$];
	vec_t known_q[$];
	vec_t dir_tab[$];
	int n_fail = 0;
	int n_done = 0;
	longint cycles = 0;
	bit quiet = 0;

	always #4 clk = ~clk;

	fixed_point_sin_cos_tan i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	function automatic longint fx_mul(longint a, longint b);
		logic signed [127:0] p;
		p = ($signed(128'(a)) * $signed(128'(b))) >>> FB;
		if (p > 128'sh7FFFFFFFFFFFFFFF)
			return 64'h7FFFFFFFFFFFFFFF;
		if (p < -128'sh8000000000000000)
			return 64'h8000000000000000;
		return longint'(p[63:0]);
	endfunction

	function automatic longint fx_quot(longint a, longint b);
		logic signed [127:0] q;
		q = ($signed(128'(a)) <<< FB) / $signed(128'(b));
		if (q > 128'sh7FFFFFFFFFFFFFFF)
			return 64'h7FFFFFFFFFFFFFFF;
		if (q < -128'sh8000000000000000)
			return 64'h8000000000000000;
		return longint'(q[63:0]);
	endfunction

	function automatic longint taylor_sine(longint x);
		longint x2, sum, term;
		longint k;
		x2 = fx_mul(x, x);
		sum = x;
		term = x;
		for (int i = 0; i < NTERMS; i++) begin
			if (mag64(term) <= (64'd1 << (FB - 24)))
				break;
			k = series_div(3'(i));
			term = fx_mul(term, x2) / k;
			sum = (i % 2 == 0) ? sum - term : sum + term;
		end
		return sum;
	endfunction

	// fold a reduced angle in [0, 2pi) into the first quadrant
	function automatic longint sine_of_reduced(longint n);
		if (n <= HALF_PI_FX)
			return taylor_sine(n);
		if (n <= PI_FX)
			return taylor_sine(PI_FX - n);
		if (n <= PI_FX + HALF_PI_FX)
			return -taylor_sine(n - PI_FX);
		return -taylor_sine(TWO_PI_FX - n);
	endfunction

	function automatic longint wrap_angle(longint a);
		longint r;
		r = a % TWO_PI_FX;
		if (r < 0)
			r += TWO_PI_FX;
		return r;
	endfunction

	function automatic longint cosine_of(longint a);
		longint n;
		n = wrap_angle(a) + HALF_PI_FX;
		if (n >= TWO_PI_FX)
			n -= TWO_PI_FX;
		return sine_of_reduced(n);
	endfunction

	function automatic trig_t predict_trig(mode_t m, longint a);
		trig_t t;
		longint c;
		t.res = 0;
		t.guard = 0;
		case (m)
			MODE_SIN: t.res = sine_of_reduced(wrap_angle(a));
			MODE_COS: t.res = cosine_of(a);
			MODE_TAN: begin
				c = cosine_of(a);
				if (mag64(c) < (64'd1 << (FB - 20)))
					t.guard = 1;
				else
					t.res = fx_quot(sine_of_reduced(wrap_angle(a)), c);
			end
			default: ;
		endcase
		return t;
	endfunction

	always @(posedge clk) begin
		trig_t e;
		vec_t v;
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
		if (s_axis_tvalid && s_axis_tready)
			pending_q.push_back(predict_trig(mode_t'(s_axis_tuser), longint'(s_axis_tdata)));
		if (m_axis_tvalid && m_axis_tready) begin
			n_done++;
			if (pending_q.size() == 0) begin
				n_fail++;
				$display("%0t: result %h with no request waiting", $time, m_axis_tdata);
			end else begin
				e = pending_q.pop_front();
				// typed-in expectations must agree with the predictor as well
				if (known_q.size() != 0 && n_done <= dir_tab.size()) begin
					v = known_q.pop_front();
					if (v.known && (v.res != e.res || v.guard != e.guard)) begin
						n_fail++;
						$display("%0t: table expects %h/%0d, predictor %h/%0d", $time,
							v.res, v.guard, e.res, e.guard);
					end
				end
				if (longint'(m_axis_tdata) != e.res) begin
					n_fail++;
					$display("%0t: result expected %h actual %h", $time, e.res, m_axis_tdata);
				end
				if (m_axis_tuser != e.guard) begin
					n_fail++;
					$display("%0t: tan_guarded expected %0d actual %0d", $time, e.guard,
						m_axis_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 26);
	end

	task automatic send_angle(mode_t m, longint a);
		while (!quiet && $urandom_range(99) < 26) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= m;
		s_axis_tdata <= a;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic vec_t row(mode_t m, longint a, bit k, longint r, bit g);
		vec_t v;
		v.mode = m;
		v.angle = a;
		v.known = k;
		v.res = r;
		v.guard = g;
		return v;
	endfunction

	function automatic longint pick_angle();
		case ($urandom_range(5))
			0: return longint'({$urandom, $urandom});
			1: return longint'($urandom_range(8)) * HALF_PI_FX + $signed(4'($urandom));
			2: return HALF_PI_FX * (2 * longint'($urandom_range(20)) - 19)
				+ $signed(12'($urandom));
			3: return -longint'({$urandom_range(3), $urandom});
			default: return longint'({$urandom_range(7), $urandom})
				* ($urandom_range(1) ? 1 : -1);
		endcase
	endfunction

	initial begin
		mode_t m;
		dir_tab.push_back(row(MODE_SIN, 0, 1, 0, 0));
		dir_tab.push_back(row(MODE_TAN, 0, 1, 0, 0));
		dir_tab.push_back(row(MODE_NONE, ONE_FX, 1, 0, 0));
		dir_tab.push_back(row(MODE_NONE, 64'h8000000000000000, 1, 0, 0));
		dir_tab.push_back(row(MODE_TAN, HALF_PI_FX, 1, 0, 1));
		dir_tab.push_back(row(MODE_TAN, PI_FX + HALF_PI_FX, 1, 0, 1));
		dir_tab.push_back(row(MODE_COS, 0, 0, 0, 0));
		dir_tab.push_back(row(MODE_SIN, HALF_PI_FX, 0, 0, 0));
		dir_tab.push_back(row(MODE_SIN, PI_FX, 0, 0, 0));
		dir_tab.push_back(row(MODE_SIN, PI_FX + HALF_PI_FX, 0, 0, 0));
		dir_tab.push_back(row(MODE_SIN, TWO_PI_FX - 1, 0, 0, 0));
		dir_tab.push_back(row(MODE_SIN, -ONE_FX, 0, 0, 0));
		dir_tab.push_back(row(MODE_SIN, 64'h7FFFFFFFFFFFFFFF, 0, 0, 0));
		dir_tab.push_back(row(MODE_SIN, 64'h8000000000000000, 0, 0, 0));
		dir_tab.push_back(row(MODE_COS, 64'h7FFFFFFFFFFFFFFF, 0, 0, 0));
		dir_tab.push_back(row(MODE_COS, 64'h8000000000000000, 0, 0, 0));
		dir_tab.push_back(row(MODE_COS, PI_FX + HALF_PI_FX, 0, 0, 0));
		dir_tab.push_back(row(MODE_TAN, HALF_PI_FX - 5000, 0, 0, 0));
		dir_tab.push_back(row(MODE_TAN, HALF_PI_FX + 5000, 0, 0, 0));
		dir_tab.push_back(row(MODE_TAN, HALF_PI_FX - 200, 0, 0, 0));
		dir_tab.push_back(row(MODE_TAN, -ONE_FX, 0, 0, 0));
		dir_tab.push_back(row(MODE_TAN, 64'h7FFFFFFFFFFFFFFF, 0, 0, 0));
		dir_tab.push_back(row(MODE_SIN, 1, 0, 0, 0));
		foreach (dir_tab[i])
			known_q.push_back(dir_tab[i]);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_angle(dir_tab[i].mode, dir_tab[i].angle);
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 300 && i < 450);
			m = ($urandom_range(39) == 0) ? MODE_NONE : mode_t'($urandom_range(2));
			send_angle(m, pick_angle());
		end
		s_axis_tvalid <= 1'b0;
		quiet = 0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (3000) @(posedge clk);
		$display("Covered %0d sine/cosine/tangent requests: table rows, range ends,",
			n_done);
		$display("quadrant edges, tangent guard and random angles under random stalls.");
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
